[src/kvp_pkg.sv]
// Shared types and constants of the section/key/value message parser.
`default_nettype none
package kvp_pkg;

	localparam int SECTION_MAX = 64;
	localparam int KEY_MAX     = 64;
	localparam int VALUE_MAX   = 128;
	localparam int ENTRIES     = 64;

	localparam int CUR_W = 8;
	localparam int POS_W = 7;
	localparam int IDX_W = 6;

	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h80;

	typedef enum logic [2:0] {
		PH_AWAIT_SECTION = 3'd0,
		PH_IN_SECTION    = 3'd1,
		PH_AWAIT_KEY     = 3'd2,
		PH_IN_KEY        = 3'd3,
		PH_AWAIT_VALUE   = 3'd4,
		PH_IN_VALUE      = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_SECTION_CHAR = 3'd0,
		EV_KEY_CHAR     = 3'd1,
		EV_VALUE_CHAR   = 3'd2,
		EV_SECTION_END  = 3'd3,
		EV_KEY_END      = 3'd4,
		EV_PAIR_DONE    = 3'd5
	} event_t;

	// True for ASCII bytes above the blank (0x21 to 0x7F), the only bytes that open a field.
	function automatic logic starts_field(input logic [7:0] b);
		return (b > CH_SPACE) && (b < CH_DEL);
	endfunction

endpackage
`default_nettype wire

[src/kvp_if.sv]
// Request channels of the message parser: input bytes and parse events.
`default_nettype none
interface kvp_in_if;
	logic       valid;
	logic       ready;
	logic       msg_start;
	logic [7:0] data_byte;

	modport source (output valid, output msg_start, output data_byte, input ready);
	modport sink   (input valid, input msg_start, input data_byte, output ready);
endinterface

interface kvp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] char_value;
	logic [6:0] position;
	logic [7:0] field_length;
	logic [5:0] entry_index;
	logic       data_lost;

	modport source (output valid, output event_kind, output char_value, output position,
		output field_length, output entry_index, output data_lost, input ready);
	modport sink   (input valid, input event_kind, input char_value, input position,
		input field_length, input entry_index, input data_lost, output ready);
endinterface
`default_nettype wire

[src/section_keyvalue_message_parser.sv]
// Top level of the section/key/value message parser.
`default_nettype none
// Parses text shaped "section{ key=value lines }" one byte per request and
// emits tagged characters, field lengths (trimmed for sections and keys) and
// pair slot indexes. A byte request is taken every cycle while results drain;
// a result is formed as its byte leaves the input register and is held in the
// result register until it is taken. The phase
// machine and its counters update as a byte leaves the input register, so
// each byte sees the state left by the one before it. Bytes that cause no
// result leave nothing in the result register. Assert msg_start with the
// first byte of a message to restart the phase machine and the slot counter.
module section_keyvalue_message_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	kvp_in_if.sink    msg,
	kvp_out_if.source evt
);

	logic       valid_s1;
	logic       start_s1;
	logic [7:0] byte_s1;

	logic       valid_s2;
	logic [2:0] kind_s2;
	logic [7:0] char_s2;
	logic [kvp_pkg::POS_W-1:0] pos_s2;
	logic [7:0] len_s2;
	logic [kvp_pkg::IDX_W-1:0] idx_s2;
	logic       lost_s2;

	kvp_pkg::phase_t phase_q, phase_cur, phase_d;
	logic [kvp_pkg::CUR_W-1:0] cursor_q, cursor_d;
	logic [kvp_pkg::CUR_W-1:0] trim_q, trim_d;
	logic                      kspace_q, kspace_d;
	logic [kvp_pkg::IDX_W-1:0] pair_q, pair_cur, pair_d;

	logic       res_v;
	kvp_pkg::event_t res_kind;
	logic [7:0] res_char;
	logic [kvp_pkg::POS_W-1:0] res_pos;
	logic [7:0] res_len;
	logic [kvp_pkg::IDX_W-1:0] res_idx;
	logic       res_lost;

	logic advance;
	logic [kvp_pkg::CUR_W-1:0] cursor_inc;

	assign advance   = valid_s1 && (!valid_s2 || evt.ready);
	assign msg.ready = !valid_s1 || advance;

	assign phase_cur  = start_s1 ? kvp_pkg::PH_AWAIT_SECTION : phase_q;
	assign pair_cur   = start_s1 ? '0 : pair_q;
	assign cursor_inc = cursor_q + kvp_pkg::CUR_W'(1);

	// Next phase.
	always_comb begin
		phase_d = phase_cur;
		case (phase_cur)
			kvp_pkg::PH_AWAIT_SECTION: begin
				if (kvp_pkg::starts_field(byte_s1))
					phase_d = kvp_pkg::PH_IN_SECTION;
			end
			kvp_pkg::PH_IN_SECTION: begin
				if (byte_s1 == kvp_pkg::CH_OPEN)
					phase_d = kvp_pkg::PH_AWAIT_KEY;
			end
			kvp_pkg::PH_AWAIT_KEY: begin
				if (byte_s1 == kvp_pkg::CH_CLOSE)
					phase_d = kvp_pkg::PH_AWAIT_SECTION;
				else if (kvp_pkg::starts_field(byte_s1))
					phase_d = kvp_pkg::PH_IN_KEY;
			end
			kvp_pkg::PH_IN_KEY: begin
				if (byte_s1 < kvp_pkg::CH_SPACE || byte_s1 == kvp_pkg::CH_EQ)
					phase_d = kvp_pkg::PH_AWAIT_VALUE;
			end
			kvp_pkg::PH_AWAIT_VALUE: begin
				if (kvp_pkg::starts_field(byte_s1))
					phase_d = kvp_pkg::PH_IN_VALUE;
			end
			kvp_pkg::PH_IN_VALUE: begin
				if (byte_s1 < kvp_pkg::CH_SPACE)
					phase_d = kvp_pkg::PH_AWAIT_KEY;
			end
			default: phase_d = kvp_pkg::PH_AWAIT_SECTION;
		endcase
	end

	// Result and counter updates.
	always_comb begin
		res_v    = 1'b0;
		res_kind = kvp_pkg::EV_SECTION_CHAR;
		res_char = '0;
		res_pos  = '0;
		res_len  = '0;
		res_idx  = '0;
		res_lost = 1'b0;
		cursor_d = cursor_q;
		trim_d   = trim_q;
		kspace_d = kspace_q;
		pair_d   = pair_cur;
		case (phase_cur)
			kvp_pkg::PH_AWAIT_SECTION: begin
				if (kvp_pkg::starts_field(byte_s1)) begin
					res_v    = 1'b1;
					res_kind = kvp_pkg::EV_SECTION_CHAR;
					res_char = byte_s1;
					cursor_d = kvp_pkg::CUR_W'(1);
					trim_d   = kvp_pkg::CUR_W'(1);
				end
			end
			kvp_pkg::PH_IN_SECTION: begin
				if (byte_s1 == kvp_pkg::CH_OPEN) begin
					res_v    = 1'b1;
					res_kind = kvp_pkg::EV_SECTION_END;
					res_len  = trim_q;
				end else if (cursor_q < kvp_pkg::CUR_W'(kvp_pkg::SECTION_MAX)) begin
					res_v    = 1'b1;
					res_kind = kvp_pkg::EV_SECTION_CHAR;
					res_char = byte_s1;
					res_pos  = cursor_q[kvp_pkg::POS_W-1:0];
					cursor_d = cursor_inc;
					if (byte_s1 > kvp_pkg::CH_SPACE)
						trim_d = cursor_inc;
				end
			end
			kvp_pkg::PH_AWAIT_KEY: begin
				if (byte_s1 != kvp_pkg::CH_CLOSE && kvp_pkg::starts_field(byte_s1)) begin
					res_v    = 1'b1;
					res_kind = kvp_pkg::EV_KEY_CHAR;
					res_char = byte_s1;
					cursor_d = kvp_pkg::CUR_W'(1);
					kspace_d = 1'b0;
				end
			end
			kvp_pkg::PH_IN_KEY: begin
				if (byte_s1 >= kvp_pkg::CH_SPACE && byte_s1 != kvp_pkg::CH_EQ) begin
					if (cursor_q < kvp_pkg::CUR_W'(kvp_pkg::KEY_MAX)) begin
						res_v    = 1'b1;
						res_kind = kvp_pkg::EV_KEY_CHAR;
						res_char = byte_s1;
						res_pos  = cursor_q[kvp_pkg::POS_W-1:0];
						cursor_d = cursor_inc;
						kspace_d = (byte_s1 == kvp_pkg::CH_SPACE);
					end
				end else begin
					res_v    = 1'b1;
					res_kind = kvp_pkg::EV_KEY_END;
					// Drop one trailing space from the key.
					if (kspace_q && cursor_q != '0)
						res_len = cursor_q - 8'd1;
					else
						res_len = cursor_q;
				end
			end
			kvp_pkg::PH_AWAIT_VALUE: begin
				if (kvp_pkg::starts_field(byte_s1)) begin
					res_v    = 1'b1;
					res_kind = kvp_pkg::EV_VALUE_CHAR;
					res_char = byte_s1;
					cursor_d = kvp_pkg::CUR_W'(1);
				end
			end
			kvp_pkg::PH_IN_VALUE: begin
				if (byte_s1 >= kvp_pkg::CH_SPACE) begin
					if (cursor_q < kvp_pkg::CUR_W'(kvp_pkg::VALUE_MAX)) begin
						res_v    = 1'b1;
						res_kind = kvp_pkg::EV_VALUE_CHAR;
						res_char = byte_s1;
						res_pos  = cursor_q[kvp_pkg::POS_W-1:0];
						cursor_d = cursor_inc;
					end
				end else begin
					res_v    = 1'b1;
					res_kind = kvp_pkg::EV_PAIR_DONE;
					res_len  = cursor_q;
					res_idx  = pair_cur;
					// Wrap the slot counter once the table is full.
					if (pair_cur >= kvp_pkg::IDX_W'(kvp_pkg::ENTRIES - 1)) begin
						pair_d   = '0;
						res_lost = 1'b1;
					end else begin
						pair_d = pair_cur + kvp_pkg::IDX_W'(1);
					end
				end
			end
			default: res_v = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= kvp_pkg::PH_AWAIT_SECTION;
			cursor_q <= '0;
			trim_q   <= '0;
			kspace_q <= 1'b0;
			pair_q   <= '0;
		end else begin
			if (msg.ready)
				valid_s1 <= msg.valid;
			if (advance) begin
				phase_q  <= phase_d;
				cursor_q <= cursor_d;
				trim_q   <= trim_d;
				kspace_q <= kspace_d;
				pair_q   <= pair_d;
				valid_s2 <= res_v;
			end else if (evt.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			start_s1 <= msg.msg_start;
			byte_s1  <= msg.data_byte;
		end
		if (advance && res_v) begin
			kind_s2 <= res_kind;
			char_s2 <= res_char;
			pos_s2  <= res_pos;
			len_s2  <= res_len;
			idx_s2  <= res_idx;
			lost_s2 <= res_lost;
		end
	end

	assign evt.valid        = valid_s2;
	assign evt.event_kind   = kind_s2;
	assign evt.char_value   = char_s2;
	assign evt.position     = pos_s2;
	assign evt.field_length = len_s2;
	assign evt.entry_index  = idx_s2;
	assign evt.data_lost    = lost_s2;

	a_lost_at_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && lost_s2 |-> kind_s2 == kvp_pkg::EV_PAIR_DONE
			&& idx_s2 == kvp_pkg::IDX_W'(kvp_pkg::ENTRIES - 1))
		else $error("data_lost without a pair in the last slot");

	a_end_has_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (kind_s2 == kvp_pkg::EV_SECTION_END || kind_s2 == kvp_pkg::EV_KEY_END
			|| kind_s2 == kvp_pkg::EV_PAIR_DONE) |-> char_s2 == '0 && pos_s2 == '0)
		else $error("field end carries a character");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!msg.ready |-> valid_s1 && valid_s2 && !evt.ready)
		else $error("input stalled with room in the pipeline");

	a_cursor_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= kvp_pkg::CUR_W'(kvp_pkg::VALUE_MAX)
			&& trim_q <= kvp_pkg::CUR_W'(kvp_pkg::SECTION_MAX))
		else $error("field cursor out of range");

endmodule
`default_nettype wire

[tb/kvp_event_checker.sv]
// Checker for the message parser: predicts parse events from byte requests and compares them.
module kvp_event_checker
	import kvp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	kvp_in_if    in_ch,
	kvp_out_if   out_ch,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		event_t     kind;
		logic [7:0] ch;
		logic [6:0] pos;
		logic [7:0] len;
		logic [5:0] slot;
		logic       lost;
	} parse_event_t;

	parse_event_t event_q [$];

	phase_t     ph;
	logic [7:0] cursor;
	logic [6:0] sect_trim;
	logic       key_space;
	logic [5:0] next_slot;

	// ASCII above the blank (0x21 to 0x7F) opens a field; high bytes never do.
	function automatic logic opens_field(input logic [7:0] b);
		return (b > 8'd32) && !b[7];
	endfunction

	// Advance the parse state by one byte; return 1 when the byte yields an event.
	function automatic bit parse_byte(input logic start, input logic [7:0] b,
		output parse_event_t ev);
		logic [7:0] len;
		ev = '0;
		if (start) begin
			ph = PH_AWAIT_SECTION;
			next_slot = '0;
		end
		case (ph)
		PH_AWAIT_SECTION: begin
			if (opens_field(b)) begin
				ph = PH_IN_SECTION;
				cursor = 8'd1;
				sect_trim = 7'd1;
				ev.kind = EV_SECTION_CHAR;
				ev.ch = b;
				return 1'b1;
			end
		end
		PH_IN_SECTION: begin
			if (b == CH_OPEN) begin
				ph = PH_AWAIT_KEY;
				ev.kind = EV_SECTION_END;
				ev.len = {1'b0, sect_trim};
				return 1'b1;
			end
			if (cursor < SECTION_MAX) begin
				ev.kind = EV_SECTION_CHAR;
				ev.ch = b;
				ev.pos = cursor[6:0];
				cursor = cursor + 8'd1;
				// trailing blanks do not count toward the section length
				if (b > CH_SPACE)
					sect_trim = cursor[6:0];
				return 1'b1;
			end
		end
		PH_AWAIT_KEY: begin
			if (b == CH_CLOSE) begin
				ph = PH_AWAIT_SECTION;
			end else if (opens_field(b)) begin
				ph = PH_IN_KEY;
				cursor = 8'd1;
				key_space = 1'b0;
				ev.kind = EV_KEY_CHAR;
				ev.ch = b;
				return 1'b1;
			end
		end
		PH_IN_KEY: begin
			if (b >= CH_SPACE && b != CH_EQ) begin
				if (cursor < KEY_MAX) begin
					ev.kind = EV_KEY_CHAR;
					ev.ch = b;
					ev.pos = cursor[6:0];
					cursor = cursor + 8'd1;
					key_space = (b == CH_SPACE);
					return 1'b1;
				end
			end else begin
				len = cursor;
				if (key_space && len != 8'd0)
					len = len - 8'd1;
				ph = PH_AWAIT_VALUE;
				ev.kind = EV_KEY_END;
				ev.len = len;
				return 1'b1;
			end
		end
		PH_AWAIT_VALUE: begin
			if (opens_field(b)) begin
				ph = PH_IN_VALUE;
				cursor = 8'd1;
				ev.kind = EV_VALUE_CHAR;
				ev.ch = b;
				return 1'b1;
			end
		end
		PH_IN_VALUE: begin
			if (b >= CH_SPACE) begin
				if (cursor < VALUE_MAX) begin
					ev.kind = EV_VALUE_CHAR;
					ev.ch = b;
					ev.pos = cursor[6:0];
					cursor = cursor + 8'd1;
					return 1'b1;
				end
			end else begin
				ev.kind = EV_PAIR_DONE;
				ev.len = cursor;
				ev.slot = next_slot;
				// wrap the slot index once the table is full
				if (next_slot == ENTRIES - 1) begin
					ev.lost = 1'b1;
					next_slot = '0;
				end else begin
					next_slot = next_slot + 6'd1;
				end
				ph = PH_AWAIT_KEY;
				return 1'b1;
			end
		end
		default: ph = PH_AWAIT_SECTION;
		endcase
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_event_t ev;
		parse_event_t want;
		parse_event_t got;
		if (!arst_n) begin
			ph = PH_AWAIT_SECTION;
			cursor = '0;
			sect_trim = '0;
			key_space = 1'b0;
			next_slot = '0;
			event_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// compare before predicting: a result never belongs to this edge's request
			if (out_ch.valid && out_ch.ready) begin
				got = '{event_t'(out_ch.event_kind), out_ch.char_value, out_ch.position,
					out_ch.field_length, out_ch.entry_index, out_ch.data_lost};
				if (event_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected event kind %0d char %h pos %0d len %0d",
							$time, got.kind, got.ch, got.pos, got.len);
				end else begin
					want = event_q.pop_front();
					if (got.kind !== want.kind || got.ch !== want.ch || got.pos !== want.pos ||
						got.len !== want.len || got.slot !== want.slot ||
						got.lost !== want.lost) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: event mismatch (expected/actual) kind %0d/%0d ",
								"char %h/%h pos %0d/%0d len %0d/%0d slot %0d/%0d lost %0d/%0d"},
								$time, want.kind, got.kind, want.ch, got.ch, want.pos, got.pos,
								want.len, got.len, want.slot, got.slot, want.lost, got.lost);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (parse_byte(in_ch.msg_start, in_ch.data_byte, ev))
					event_q.push_back(ev);
			end
			pending = event_q.size();
		end
	end

endmodule

[tb/section_keyvalue_message_parser_tb.sv]
// Testbench top of the message parser: byte stimulus, result back-pressure and verdict.
module section_keyvalue_message_parser_tb;
	import kvp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 200;
	localparam int ITEM_COUNT  = 450;
	localparam int TABLE_PAIRS = ENTRIES + 3;

	localparam logic [7:0] DIRECTED_TEXT [24] = '{
		CH_SPACE, 8'hFF, 8'h00, 8'h7F, 8'h21, 8'h80, CH_SPACE, 8'h1F, CH_OPEN,
		8'hFF, 8'h21, 8'h80, CH_SPACE, CH_EQ,
		CH_SPACE, 8'h7E, CH_SPACE, 8'hFF, 8'h00,
		CH_EQ, 8'h1F,
		CH_CLOSE, 8'h09,
		CH_CLOSE
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kvp_in_if  msg_ch ();
	kvp_out_if evt_ch ();

	int fail_count;
	int pending;
	int items_sent = 0;
	int stall_cycles = 0;
	bit idle_on = 1'b1;
	bit hold_rx = 1'b0;
	logic [7:0] text_q [$];

	always #6 clk = ~clk;

	section_keyvalue_message_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_ch),
		.evt(evt_ch)
	);

	kvp_event_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(msg_ch),
		.out_ch(evt_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (msg_ch.valid && msg_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("section_keyvalue_message_parser_tb: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		evt_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				hold_rx = 1'b0;
				evt_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				evt_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				evt_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				evt_ch.ready <= 1'b1;
			end else begin
				evt_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic start, input logic [7:0] b);
		msg_ch.valid     <= 1'b1;
		msg_ch.msg_start <= start;
		msg_ch.data_byte <= b;
		do @(posedge clk); while (!msg_ch.ready);
		items_sent++;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_text(input bit restart);
		foreach (text_q[i])
			send_byte(restart && i == 0, text_q[i]);
		text_q.delete();
	endtask

	// Hold requests until every predicted event has come out.
	task automatic drain();
		msg_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Bytes that the waiting phases skip: blanks, controls and high bytes.
	function automatic logic [7:0] skip_byte();
		case ($urandom_range(0, 2))
		0: return CH_SPACE;
		1: return 8'($urandom_range(0, 31));
		default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	function automatic logic [7:0] opener(input bit not_close);
		logic [7:0] b;
		do b = 8'($urandom_range(33, 127)); while (not_close && b == CH_CLOSE);
		return b;
	endfunction

	function automatic logic [7:0] section_char();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 3) != 0)
				b = 8'($urandom_range(33, 126));
			else
				b = 8'($urandom_range(0, 255));
		end while (b == CH_OPEN);
		return b;
	endfunction

	function automatic logic [7:0] key_char();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 3) != 0)
				b = 8'($urandom_range(33, 126));
			else
				b = 8'($urandom_range(32, 255));
		end while (b == CH_EQ);
		return b;
	endfunction

	// Mostly short fields; now and then one near or past the limit.
	function automatic int field_len(input int limit);
		if ($urandom_range(0, 39) == 0)
			return $urandom_range(limit - 2, limit + 6);
		return $urandom_range(1, 6);
	endfunction

	task automatic build_message();
		int n;
		repeat ($urandom_range(0, 2)) text_q.push_back(skip_byte());
		text_q.push_back(opener(1'b0));
		n = field_len(SECTION_MAX);
		repeat (n - 1) text_q.push_back(section_char());
		repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(0, 32)));
		text_q.push_back(CH_OPEN);
		repeat ($urandom_range(0, 4)) begin
			repeat ($urandom_range(0, 1)) text_q.push_back(skip_byte());
			text_q.push_back(opener(1'b1));
			n = field_len(KEY_MAX);
			repeat (n - 1) text_q.push_back(key_char());
			if ($urandom_range(0, 2) == 0)
				text_q.push_back(CH_SPACE);
			text_q.push_back($urandom_range(0, 1) ? CH_EQ : 8'($urandom_range(0, 31)));
			repeat ($urandom_range(0, 1)) text_q.push_back(skip_byte());
			text_q.push_back(opener(1'b0));
			n = field_len(VALUE_MAX);
			repeat (n - 1) text_q.push_back(8'($urandom_range(32, 255)));
			text_q.push_back(8'($urandom_range(0, 31)));
		end
		text_q.push_back(CH_CLOSE);
	endtask

	initial begin
		int cut;
		int shape;
		msg_ch.valid     <= 1'b0;
		msg_ch.msg_start <= 1'b0;
		msg_ch.data_byte <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_TEXT[i])
			text_q.push_back(DIRECTED_TEXT[i]);
		send_text(1'b1);
		drain();

		// Fill the pair table past its end while the result side holds off.
		hold_rx = 1'b1;
		text_q.push_back(opener(1'b0));
		text_q.push_back(CH_OPEN);
		repeat (TABLE_PAIRS) begin
			text_q.push_back(opener(1'b1));
			text_q.push_back(CH_EQ);
			text_q.push_back(opener(1'b0));
			text_q.push_back(8'h0A);
		end
		text_q.push_back(CH_CLOSE);
		send_text(1'b1);
		drain();

		while (items_sent < ITEM_COUNT) begin
			if (items_sent >= ITEM_COUNT * 9 / 10)
				idle_on = 1'b0;
			else if ($urandom_range(0, 7) == 0)
				idle_on = !idle_on;
			shape = $urandom_range(0, 9);
			if (shape == 0) begin
				repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				build_message();
				// drop the tail of a broken message
				if (shape == 1) begin
					cut = $urandom_range(1, text_q.size());
					while (text_q.size() > cut)
						void'(text_q.pop_back());
				end
			end
			send_text($urandom_range(0, 3) == 0);
		end
		drain();
		repeat (6) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("section_keyvalue_message_parser_tb: PASS");
		else
			$display("section_keyvalue_message_parser_tb: FAIL");
		$finish;
	end

endmodule

[section_keyvalue_message_parser.f]
src/kvp_pkg.sv
src/kvp_if.sv
src/section_keyvalue_message_parser.sv
tb/kvp_event_checker.sv
tb/section_keyvalue_message_parser_tb.sv
